FILE: rtl/pcf_pkg.sv
package pcf_pkg;

   localparam int DIV_STEPS   = 24;
   localparam int MAG_BITS    = 24;
   localparam int PREC_SHIFT  = 20;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CHARGE_X        = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHARGE_Y        = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHARGE_STRENGTH = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHARGE_POSITIVE = 2'd3;

   localparam int CHARGE_X_RESET        = 320;
   localparam int CHARGE_Y_RESET        = 240;
   localparam logic [31:0] CHARGE_STRENGTH_RESET = 32'd8990;

   localparam logic [31:0] TURN_HALF     = 32'h8000_0000;
   localparam logic [31:0] ANGLE_AT_ZERO = 32'hC000_0000;
   localparam logic [31:0] GAIN_INV_Q30  = 32'd652032874;
   localparam logic [MAG_BITS-1:0] MAG_MAX = 24'hFF_FFFF;

   localparam int DEF_COORD_BITS   = 10;
   localparam int DEF_ANGLE_BITS   = 16;
   localparam int DEF_CORDIC_STEPS = 16;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic [31:0] atan_turn(input int idx);
      logic [31:0] val;
      case (idx)
         0:  val = 32'd536870912;
         1:  val = 32'd316933406;
         2:  val = 32'd167458907;
         3:  val = 32'd85004756;
         4:  val = 32'd42667331;
         5:  val = 32'd21354465;
         6:  val = 32'd10679838;
         7:  val = 32'd5340245;
         8:  val = 32'd2670163;
         9:  val = 32'd1335087;
         10: val = 32'd667544;
         11: val = 32'd333772;
         12: val = 32'd166886;
         13: val = 32'd83443;
         14: val = 32'd41722;
         15: val = 32'd20861;
         16: val = 32'd10430;
         17: val = 32'd5215;
         18: val = 32'd2608;
         19: val = 32'd1304;
         20: val = 32'd652;
         21: val = 32'd326;
         22: val = 32'd163;
         23: val = 32'd81;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

FILE: rtl/point_charge_field_vector.sv
// Field of one configured point charge, one grid point per word.
// req_ carries a grid point; rsp_ returns field magnitude (16.8, saturating),
// direction as a fraction of a turn, the arrow tip and a clip flag.
// csr_ writes charge_x, charge_y, charge_strength and charge_positive by
// index; write only while no words are in flight.
// Throughput: one word per cycle while the output does not stall. From req
// acceptance to rsp valid, the offsets and squared distance are registered as
// the word is taken, then it passes the queue, one entry stage, the restoring
// divider (24 steps) in parallel with the vectoring CORDIC and then the
// rotation CORDIC, one multiply stage and one output stage.
// Reset clears all valid bits and loads the register reset values.
// When rsp_tvalid is high and rsp_tready low the back pipeline holds; the front
// fills the four-word queue, then its own register, and then drops req_tready.
module point_charge_field_vector #(
   parameter int COORD_BITS   = pcf_pkg::DEF_COORD_BITS,
   parameter int ANGLE_BITS   = pcf_pkg::DEF_ANGLE_BITS,
   parameter int CORDIC_STEPS = pcf_pkg::DEF_CORDIC_STEPS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // point_x, point_y, zero fill
   input  logic [((2*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // field_magnitude[23:0], field_angle[39:24], tip_x[55:40], tip_y[71:56],
   // clipped[72], zero fill
   output logic [79:0] rsp_tdata,
   input  logic csr_we,
   input  logic [pcf_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [pcf_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   localparam int FW = 6 * COORD_BITS + 3;

   logic [COORD_BITS-1:0] charge_x_ff, charge_y_ff;
   logic [31:0] charge_strength_ff;
   logic charge_positive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         charge_x_ff        <= COORD_BITS'(pcf_pkg::CHARGE_X_RESET);
         charge_y_ff        <= COORD_BITS'(pcf_pkg::CHARGE_Y_RESET);
         charge_strength_ff <= pcf_pkg::CHARGE_STRENGTH_RESET;
         charge_positive_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            pcf_pkg::CSR_CHARGE_X:        charge_x_ff <= csr_wdata[COORD_BITS-1:0];
            pcf_pkg::CSR_CHARGE_Y:        charge_y_ff <= csr_wdata[COORD_BITS-1:0];
            pcf_pkg::CSR_CHARGE_STRENGTH: charge_strength_ff <= csr_wdata[31:0];
            pcf_pkg::CSR_CHARGE_POSITIVE: charge_positive_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic f_valid, f_ready, q_valid, q_ready;
   logic [FW-1:0] f_data, q_data;
   logic [pcf_pkg::MAG_BITS-1:0] field_magnitude;
   logic [15:0] field_angle;
   logic signed [15:0] tip_x, tip_y;
   logic clipped;

   pcf_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .point(req_tdata[2*COORD_BITS-1:0]),
      .charge_x(charge_x_ff), .charge_y(charge_y_ff),
      .f_valid(f_valid), .f_ready(f_ready), .f_data(f_data)
   );

   pcf_queue #(.WIDTH(FW)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   pcf_back #(
      .COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)
   ) u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .charge_strength(charge_strength_ff), .charge_positive(charge_positive_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .field_magnitude(field_magnitude), .field_angle(field_angle),
      .tip_x(tip_x), .tip_y(tip_y), .clipped(clipped)
   );

   assign rsp_tdata = {7'd0, clipped, tip_y, tip_x, field_angle, field_magnitude};

endmodule

FILE: rtl/pcf_front.sv
module pcf_front #(
   parameter int COORD_BITS = pcf_pkg::DEF_COORD_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [2*COORD_BITS-1:0] point,
   input  logic [COORD_BITS-1:0] charge_x,
   input  logic [COORD_BITS-1:0] charge_y,
   output logic f_valid,
   input  logic f_ready,
   output logic [4*COORD_BITS+2+2*COORD_BITS:0] f_data
);
   localparam int DW  = COORD_BITS + 1;
   localparam int R2W = 2 * COORD_BITS + 1;

   logic f_vld_ff;
   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic signed [DW-1:0] dx_ff, dy_ff;
   logic [R2W-1:0] r2_ff;

   logic signed [DW-1:0] dx_in, dy_in;
   logic signed [2*DW-1:0] sqx, sqy;
   logic [R2W-1:0] r2_in;
   logic take;

   assign req_tready = !f_vld_ff || f_ready;
   assign take = req_tvalid && req_tready;

   always_comb begin
      dx_in = $signed({1'b0, point[COORD_BITS-1:0]}) - $signed({1'b0, charge_x});
      dy_in = $signed({1'b0, point[2*COORD_BITS-1:COORD_BITS]}) - $signed({1'b0, charge_y});
      sqx   = dx_in * dx_in;
      sqy   = dy_in * dy_in;
      r2_in = sqx[R2W-1:0] + sqy[R2W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (req_tready) begin
         f_vld_ff <= req_tvalid;
      end
      if (take) begin
         px_ff <= point[COORD_BITS-1:0];
         py_ff <= point[2*COORD_BITS-1:COORD_BITS];
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         r2_ff <= r2_in;
      end
   end

   assign f_valid = f_vld_ff;
   assign f_data  = {r2_ff, dy_ff, dx_ff, py_ff, px_ff};

endmodule

FILE: rtl/pcf_queue.sv
module pcf_queue #(
   parameter int WIDTH = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic out_valid,
   input  logic out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int DEPTH = pcf_pkg::QUEUE_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic push, pop;

   assign in_ready  = count_ff != CW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("queue count overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a push");

endmodule

FILE: rtl/pcf_back.sv
module pcf_back #(
   parameter int COORD_BITS   = pcf_pkg::DEF_COORD_BITS,
   parameter int ANGLE_BITS   = pcf_pkg::DEF_ANGLE_BITS,
   parameter int CORDIC_STEPS = pcf_pkg::DEF_CORDIC_STEPS
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [4*COORD_BITS+2+2*COORD_BITS:0] in_data,
   input  logic [31:0] charge_strength,
   input  logic charge_positive,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [pcf_pkg::MAG_BITS-1:0] field_magnitude,
   output logic [15:0] field_angle,
   output logic signed [15:0] tip_x,
   output logic signed [15:0] tip_y,
   output logic clipped
);
   localparam int DW   = COORD_BITS + 1;
   localparam int R2W  = 2 * COORD_BITS + 1;
   localparam int RW   = R2W + 1;
   localparam int MB   = pcf_pkg::MAG_BITS;
   localparam int DS   = pcf_pkg::DIV_STEPS;
   localparam int PS   = pcf_pkg::PREC_SHIFT;
   localparam int VW   = COORD_BITS + PS + 4;
   localparam int CW   = 34;
   localparam int NST  = (DS > 2 * CORDIC_STEPS) ? DS : 2 * CORDIC_STEPS;
   localparam int PW   = MB + 1 + CW;
   localparam int TW   = PW - 37;
   localparam logic [31:0] RND_ADD  = 32'(64'd1 << (31 - ANGLE_BITS));
   localparam logic [31:0] RND_MASK = ~(32'(64'd1 << (32 - ANGLE_BITS)) - 32'd1);
   localparam logic signed [PW-1:0] OFF_RND = PW'(64'd1 << 37);

   logic adv;
   logic [MB-1:0] num24;

   logic vld_ff [0:NST];
   logic [COORD_BITS-1:0] px_ff [0:NST];
   logic [COORD_BITS-1:0] py_ff [0:NST];
   logic zero_ff [0:NST];
   logic sat_ff [0:NST];
   logic [R2W-1:0] r2_ff [0:NST];
   logic [RW-1:0] rem_ff [0:NST];
   logic [MB-1:0] q_ff [0:NST];
   logic signed [VW-1:0] vx_ff [0:NST];
   logic signed [VW-1:0] vy_ff [0:NST];
   logic [31:0] vz_ff [0:NST];
   logic [31:0] ang_ff [0:NST];
   logic flip_ff [0:NST];
   logic signed [CW-1:0] rx_ff [0:NST];
   logic signed [CW-1:0] ry_ff [0:NST];
   logic signed [CW-1:0] rz_ff [0:NST];

   logic [COORD_BITS-1:0] h_px, h_py;
   logic signed [DW-1:0] h_dx, h_dy, h_dxa, h_dya;
   logic [R2W-1:0] h_r2;

   assign adv = !rsp_tvalid || rsp_tready;
   assign in_ready = adv;
   assign num24 = {charge_strength[15:0], 8'd0};
   assign {h_r2, h_dy, h_dx, h_py, h_px} = in_data;
   assign h_dxa = h_dx[DW-1] ? -h_dx : h_dx;
   assign h_dya = h_dx[DW-1] ? -h_dy : h_dy;

   // Entry stage: vector folded into the right half plane, divider seeded.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
      if (adv) begin
         px_ff[0]   <= h_px;
         py_ff[0]   <= h_py;
         r2_ff[0]   <= h_r2;
         zero_ff[0] <= h_r2 == '0;
         sat_ff[0]  <= R2W'(charge_strength[31:16]) >= h_r2;
         rem_ff[0]  <= RW'(charge_strength[31:16]);
         q_ff[0]    <= '0;
         vx_ff[0]   <= $signed({{(VW-DW-PS){h_dxa[DW-1]}}, h_dxa, {PS{1'b0}}});
         vy_ff[0]   <= $signed({{(VW-DW-PS){h_dya[DW-1]}}, h_dya, {PS{1'b0}}});
         vz_ff[0]   <= h_dx[DW-1] ? pcf_pkg::TURN_HALF : 32'd0;
         ang_ff[0]  <= '0;
         flip_ff[0] <= 1'b0;
         rx_ff[0]   <= '0;
         ry_ff[0]   <= '0;
         rz_ff[0]   <= '0;
      end
   end

   for (genvar k = 0; k < NST; k++) begin : g_st
      logic [RW-1:0] rem_in;
      logic [MB-1:0] q_in;
      logic signed [VW-1:0] vx_in, vy_in;
      logic [31:0] vz_in, ang_in;
      logic flip_in;
      logic signed [CW-1:0] rx_in, ry_in, rz_in;

      if (k < DS) begin : g_div
         logic [RW-1:0] t;
         logic ge;
         always_comb begin
            t      = {rem_ff[k][R2W-1:0], num24[DS-1-k]};
            ge     = t >= RW'(r2_ff[k]);
            rem_in = ge ? t - RW'(r2_ff[k]) : t;
            q_in   = {q_ff[k][MB-2:0], ge};
         end
      end else begin : g_div_hold
         assign rem_in = rem_ff[k];
         assign q_in   = q_ff[k];
      end

      if (k < CORDIC_STEPS) begin : g_vec
         logic signed [VW-1:0] xs, ys;
         always_comb begin
            xs = vx_ff[k] >>> k;
            ys = vy_ff[k] >>> k;
            if (!vy_ff[k][VW-1]) begin
               vx_in = vx_ff[k] + ys;
               vy_in = vy_ff[k] - xs;
               vz_in = vz_ff[k] + pcf_pkg::atan_turn(k);
            end else begin
               vx_in = vx_ff[k] - ys;
               vy_in = vy_ff[k] + xs;
               vz_in = vz_ff[k] - pcf_pkg::atan_turn(k);
            end
         end
      end else begin : g_vec_hold
         assign vx_in = vx_ff[k];
         assign vy_in = vy_ff[k];
         assign vz_in = vz_ff[k];
      end

      if (k >= CORDIC_STEPS && k < 2 * CORDIC_STEPS) begin : g_rot
         logic signed [CW-1:0] xi, yi, zi, xs, ys, at;
         if (k == CORDIC_STEPS) begin : g_prep
            logic [31:0] a1, a2;
            logic fl;
            always_comb begin
               a1 = zero_ff[k] ? pcf_pkg::ANGLE_AT_ZERO : vz_ff[k];
               if (!charge_positive) a1 = a1 ^ pcf_pkg::TURN_HALF;
               a2 = (a1 + RND_ADD) & RND_MASK;
               fl = a2[31] ^ a2[30];
               ang_in  = a2;
               flip_in = fl;
               zi = CW'($signed({a2[31] ^ fl, a2[30:0]}));
               xi = $signed({2'b00, pcf_pkg::GAIN_INV_Q30});
               yi = '0;
            end
         end else begin : g_chain
            assign ang_in  = ang_ff[k];
            assign flip_in = flip_ff[k];
            assign xi = rx_ff[k];
            assign yi = ry_ff[k];
            assign zi = rz_ff[k];
         end
         always_comb begin
            xs = xi >>> (k - CORDIC_STEPS);
            ys = yi >>> (k - CORDIC_STEPS);
            at = $signed({2'b00, pcf_pkg::atan_turn(k - CORDIC_STEPS)});
            if (!zi[CW-1]) begin
               rx_in = xi - ys;
               ry_in = yi + xs;
               rz_in = zi - at;
            end else begin
               rx_in = xi + ys;
               ry_in = yi - xs;
               rz_in = zi + at;
            end
         end
      end else begin : g_rot_hold
         assign ang_in  = ang_ff[k];
         assign flip_in = flip_ff[k];
         assign rx_in = rx_ff[k];
         assign ry_in = ry_ff[k];
         assign rz_in = rz_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (adv) begin
            px_ff[k+1]   <= px_ff[k];
            py_ff[k+1]   <= py_ff[k];
            zero_ff[k+1] <= zero_ff[k];
            sat_ff[k+1]  <= sat_ff[k];
            r2_ff[k+1]   <= r2_ff[k];
            rem_ff[k+1]  <= rem_in;
            q_ff[k+1]    <= q_in;
            vx_ff[k+1]   <= vx_in;
            vy_ff[k+1]   <= vy_in;
            vz_ff[k+1]   <= vz_in;
            ang_ff[k+1]  <= ang_in;
            flip_ff[k+1] <= flip_in;
            rx_ff[k+1]   <= rx_in;
            ry_ff[k+1]   <= ry_in;
            rz_ff[k+1]   <= rz_in;
         end
      end
   end

   // Product stage.
   logic m_vld_ff, m_clip_ff;
   logic [COORD_BITS-1:0] m_px_ff, m_py_ff;
   logic [MB-1:0] m_mag_ff;
   logic [15:0] m_ang_ff;
   logic signed [PW-1:0] m_prx_ff, m_pry_ff;
   logic [MB-1:0] mag_in;
   logic signed [CW-1:0] c_in, s_in;

   always_comb begin
      if (zero_ff[NST]) begin
         mag_in = '0;
      end else if (sat_ff[NST]) begin
         mag_in = pcf_pkg::MAG_MAX;
      end else begin
         mag_in = q_ff[NST];
      end
      c_in = flip_ff[NST] ? -rx_ff[NST] : rx_ff[NST];
      s_in = flip_ff[NST] ? -ry_ff[NST] : ry_ff[NST];
   end

   // Cosine and sine stay within about one in Q30, so 32 bits carry them.
   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= vld_ff[NST];
      end
      if (adv) begin
         m_px_ff   <= px_ff[NST];
         m_py_ff   <= py_ff[NST];
         m_mag_ff  <= mag_in;
         m_ang_ff  <= ang_ff[NST][31:16];
         m_clip_ff <= sat_ff[NST] && !zero_ff[NST];
         m_prx_ff  <= $signed({1'b0, mag_in}) * $signed(c_in[31:0]);
         m_pry_ff  <= $signed({1'b0, mag_in}) * $signed(s_in[31:0]);
      end
   end

   // Output stage: round the offset, add the point and saturate.
   logic signed [PW-1:0] sum_x, sum_y;
   logic signed [TW-1:0] tx, ty;
   logic [15:0] tx_sat, ty_sat;
   logic clip_x, clip_y;
   logic rsp_vld_ff, clip_ff;
   logic [MB-1:0] mag_ff;
   logic [15:0] ang_out_ff, tx_ff, ty_ff;

   always_comb begin
      sum_x = m_prx_ff + OFF_RND;
      sum_y = m_pry_ff + OFF_RND;
      tx = $signed({{(TW-COORD_BITS){1'b0}}, m_px_ff}) + TW'($signed(sum_x[PW-1:38]));
      ty = $signed({{(TW-COORD_BITS){1'b0}}, m_py_ff}) + TW'($signed(sum_y[PW-1:38]));
      clip_x = 1'b1;
      clip_y = 1'b1;
      if (tx > TW'(32767)) begin
         tx_sat = 16'h7FFF;
      end else if (tx < -TW'(32768)) begin
         tx_sat = 16'h8000;
      end else begin
         tx_sat = tx[15:0];
         clip_x = 1'b0;
      end
      if (ty > TW'(32767)) begin
         ty_sat = 16'h7FFF;
      end else if (ty < -TW'(32768)) begin
         ty_sat = 16'h8000;
      end else begin
         ty_sat = ty[15:0];
         clip_y = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= m_vld_ff;
      end
      if (adv) begin
         mag_ff     <= m_mag_ff;
         ang_out_ff <= m_ang_ff;
         tx_ff      <= tx_sat;
         ty_ff      <= ty_sat;
         clip_ff    <= m_clip_ff || clip_x || clip_y;
      end
   end

   assign rsp_tvalid      = rsp_vld_ff;
   assign field_magnitude = mag_ff;
   assign field_angle     = ang_out_ff;
   assign tip_x           = tx_ff;
   assign tip_y           = ty_ff;
   assign clipped         = clip_ff;

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[DS] && !zero_ff[DS] && !sat_ff[DS]) |-> rem_ff[DS] < RW'(r2_ff[DS]))
      else $error("divider remainder not below divisor");
   a_zero_quarter: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[NST] && zero_ff[NST]) |-> ang_ff[NST][29:0] == 30'd0)
      else $error("zero distance angle is not a quarter turn");

endmodule

FILE: test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 36;
   localparam int N_RANDOM = 2000;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic        clipped;
      logic [15:0] tip_y;
      logic [15:0] tip_x;
      logic [15:0] angle;
      logic [23:0] magnitude;
   } field_type;

   // Arctangent table in 2^-32 turn, as the hardware uses.
   localparam logic [31:0] ATAN_TBL [16] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861};

   class field_scoreboard_type;
      logic [9:0]  cx, cy;
      logic [31:0] strength;
      logic        positive;
      field_type   pending[$];
      int          errors, checked, clip_seen, zero_seen;

      function new();
         cx = 10'(pcf_pkg::CHARGE_X_RESET);
         cy = 10'(pcf_pkg::CHARGE_Y_RESET);
         strength = pcf_pkg::CHARGE_STRENGTH_RESET;
         positive = 1'b0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            pcf_pkg::CSR_CHARGE_X:        cx = val[9:0];
            pcf_pkg::CSR_CHARGE_Y:        cy = val[9:0];
            pcf_pkg::CSR_CHARGE_STRENGTH: strength = val;
            pcf_pkg::CSR_CHARGE_POSITIVE: positive = val[0];
            default: ;
         endcase
      endfunction

      // Arithmetic right shift on longint rounds toward minus infinity.
      function logic [31:0] vector_angle(longint dx, longint dy);
         longint x, y, xs, ys;
         logic [31:0] z;
         x = dx <<< 20;
         y = dy <<< 20;
         z = 0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = pcf_pkg::TURN_HALF;
         end
         for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys; y = y - xs; z = z + ATAN_TBL[i];
            end else begin
               x = x - ys; y = y + xs; z = z - ATAN_TBL[i];
            end
         end
         return z;
      endfunction

      function void cos_sin(logic [31:0] a, output longint c, output longint s);
         logic   flip;
         logic [31:0] res;
         longint x, y, z, xs, ys;
         flip = (a >= 32'h4000_0000) && (a < 32'hC000_0000);
         res = flip ? a - pcf_pkg::TURN_HALF : a;
         z = longint'($signed(res));
         x = pcf_pkg::GAIN_INV_Q30;
         y = 0;
         for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys; y = y + xs; z = z - ATAN_TBL[i];
            end else begin
               x = x + ys; y = y - xs; z = z + ATAN_TBL[i];
            end
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      function longint clamp16(longint v, inout logic clip);
         if (v > 32767) begin clip = 1; return 32767; end
         if (v < -32768) begin clip = 1; return -32768; end
         return v;
      endfunction

      function void note_point(logic [9:0] px, logic [9:0] py);
         longint dx, dy, c, s, tx, ty;
         longint unsigned r2, mag;
         logic [31:0] ang;
         logic clip;
         field_type f;
         dx = longint'(px) - longint'(cx);
         dy = longint'(py) - longint'(cy);
         r2 = dx * dx + dy * dy;
         mag = 0;
         clip = 0;
         if (r2 == 0) begin
            ang = pcf_pkg::ANGLE_AT_ZERO;
         end else begin
            mag = {24'd0, strength, 8'd0} / r2;
            if (mag > pcf_pkg::MAG_MAX) begin
               mag = pcf_pkg::MAG_MAX;
               clip = 1;
            end
            ang = vector_angle(dx, dy);
         end
         if (!positive) ang = ang + pcf_pkg::TURN_HALF;
         ang = (ang + 32'h8000) & 32'hFFFF_0000;
         cos_sin(ang, c, s);
         tx = clamp16(longint'(px) + ((longint'(mag) * c + (64'sd1 <<< 37)) >>> 38), clip);
         ty = clamp16(longint'(py) + ((longint'(mag) * s + (64'sd1 <<< 37)) >>> 38), clip);
         f.magnitude = mag[23:0];
         f.angle = ang[31:16];
         f.tip_x = tx[15:0];
         f.tip_y = ty[15:0];
         f.clipped = clip;
         if (clip) clip_seen++;
         if (r2 == 0) zero_seen++;
         pending.insert(pending.size(), f);
      endfunction

      function void check_field(field_type got);
         field_type want;
         if (pending.size() == 0) begin
            $error("unexpected result word %h", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.magnitude !== want.magnitude) begin
            $error("field_magnitude expected %h got %h", want.magnitude, got.magnitude);
            errors++;
         end
         if (got.angle !== want.angle) begin
            $error("field_angle expected %h got %h", want.angle, got.angle);
            errors++;
         end
         if (got.tip_x !== want.tip_x) begin
            $error("tip_x expected %h got %h", want.tip_x, got.tip_x);
            errors++;
         end
         if (got.tip_y !== want.tip_y) begin
            $error("tip_y expected %h got %h", want.tip_y, got.tip_y);
            errors++;
         end
         if (got.clipped !== want.clipped) begin
            $error("clipped expected %b got %b", want.clipped, got.clipped);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [79:0] rsp_tdata;
   logic        csr_we = 0;
   logic [1:0]  csr_index = pcf_pkg::CSR_CHARGE_X;
   logic [31:0] csr_wdata = '0;
   longint      cycles = 0;
   field_scoreboard_type board;

   point_charge_field_vector dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // Receiver stalls in runs, with an occasional long stretch of always-ready.
   int stall_mode = 0;
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) board.check_field(rsp_tdata[72:0]);
      if ((cycles % 500) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 9) < 3);
      endcase
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      board.set_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic send_point(logic [9:0] px, logic [9:0] py);
      req_tvalid <= 1'b1;
      req_tdata <= {4'd0, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_point(px, py);
   endtask

   task automatic pause_sender();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic random_points(int count);
      int burst;
      logic [9:0] px, py;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && count > 0; i++, count--) begin
            case ($urandom_range(0, 3))
               0: begin
                  px = board.cx + 10'($urandom_range(0, 6)) - 10'd3;
                  py = board.cy + 10'($urandom_range(0, 6)) - 10'd3;
               end
               default: begin
                  px = 10'($urandom);
                  py = 10'($urandom);
               end
            endcase
            send_point(px, py);
         end
         if ($urandom_range(0, 1)) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   endtask

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: corners, the charge itself, neighbors.
      send_point(10'd0, 10'd0);
      send_point(10'd1023, 10'd1023);
      send_point(10'd0, 10'd1023);
      send_point(10'd1023, 10'd0);
      send_point(10'd320, 10'd240);
      send_point(10'd321, 10'd240);
      send_point(10'd319, 10'd240);
      send_point(10'd320, 10'd241);
      send_point(10'd320, 10'd239);
      send_point(10'd330, 10'd250);
      pause_sender();

      // Positive charge, full strength: saturation of magnitude and tip.
      write_reg(pcf_pkg::CSR_CHARGE_POSITIVE, 32'd1);
      write_reg(pcf_pkg::CSR_CHARGE_STRENGTH, 32'hFFFF_FFFF);
      write_reg(pcf_pkg::CSR_CHARGE_X, 32'hFFFF_FC00);
      write_reg(pcf_pkg::CSR_CHARGE_Y, 32'd1023);
      send_point(10'd0, 10'd1023);
      send_point(10'd1, 10'd1023);
      send_point(10'd0, 10'd1022);
      send_point(10'd1023, 10'd0);
      send_point(10'd5, 10'd1020);
      pause_sender();

      // Zero strength with the charge at the far corner.
      write_reg(pcf_pkg::CSR_CHARGE_STRENGTH, 32'd0);
      write_reg(pcf_pkg::CSR_CHARGE_X, 32'd1023);
      write_reg(pcf_pkg::CSR_CHARGE_Y, 32'd0);
      send_point(10'd1023, 10'd0);
      send_point(10'd0, 10'd1023);
      send_point(10'd500, 10'd7);
      pause_sender();

      for (int phase = 0; phase < 5; phase++) begin
         write_reg(pcf_pkg::CSR_CHARGE_X, $urandom);
         write_reg(pcf_pkg::CSR_CHARGE_Y, $urandom);
         case (phase)
            0: write_reg(pcf_pkg::CSR_CHARGE_STRENGTH, 32'hFFFF_FFFF);
            1: write_reg(pcf_pkg::CSR_CHARGE_STRENGTH, $urandom_range(0, 20000));
            2: write_reg(pcf_pkg::CSR_CHARGE_STRENGTH, 32'd1);
            default: write_reg(pcf_pkg::CSR_CHARGE_STRENGTH, $urandom);
         endcase
         write_reg(pcf_pkg::CSR_CHARGE_POSITIVE, $urandom);
         random_points(N_RANDOM / 5);
         pause_sender();
      end

      $display("Checked %0d field words over several charge settings.", board.checked);
      $display("Saturated results: %0d, points on the charge: %0d.",
               board.clip_seen, board.zero_seen);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end
endmodule
